### src/binned_2d_scale_factor_lookup_assert.svh
`ifndef BINNED_2D_SCALE_FACTOR_LOOKUP_ASSERT_SVH
`define BINNED_2D_SCALE_FACTOR_LOOKUP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define BSFL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsfl assertion failed");

// next-cycle implication, off while reset is high
`define BSFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsfl assertion failed");

`endif

### src/bsfl_pkg.sv
package bsfl_pkg;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 10;
  localparam int WORD_W   = 32;
  localparam int SHIFT_W  = 16;
  localparam int COUNT_W  = 6;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int PROD_W   = WORD_W + SHIFT_W;
  localparam int SUM_W    = PROD_W + 1;

  localparam logic [WORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  // register index as seen on paddr[2]
  localparam logic REG_X_BINS = 1'b0;
  localparam logic REG_Y_BINS = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_EVAL   = 3'd0,
    OP_WR_X   = 3'd1,
    OP_WR_Y   = 3'd2,
    OP_WR_VAL = 3'd3,
    OP_WR_ERR = 3'd4
  } op_t;

  // which edge entry the search units read next
  typedef enum logic [1:0] {
    SEL_FIRST = 2'd0,
    SEL_LAST  = 2'd1,
    SEL_MID   = 2'd2
  } edge_sel_t;

  typedef struct packed {
    logic      capture;   // evaluate item accepted, latch its fields
    edge_sel_t edge_sel;
    logic      chk_lo;    // first edge on read data
    logic      check;     // last edge on read data, latch range flag
    logic      init;      // start binary searches
    logic      step;      // one probe
    logic      mul;       // cell words on read data
    logic      load_out;  // load output register
  } cmd_t;

  typedef struct packed {
    logic oor;            // point outside, valid in check cycle
    logic search_done;    // both searches finish with this probe
  } status_t;

endpackage

### src/bsfl_ram.sv
module bsfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bsfl_search.sv
module bsfl_search #(
  parameter int MAX_BINS = 32,
  localparam int AW = $clog2(MAX_BINS + 1),
  localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic                                clk,
  input  bsfl_pkg::cmd_t                      cmd,
  input  logic signed [bsfl_pkg::WORD_W-1:0]  coord,
  input  logic [AW-1:0]                       n,
  input  logic signed [bsfl_pkg::WORD_W-1:0]  rdata,
  output logic [AW-1:0]                       raddr,
  output logic                                oor,
  output logic                                done,
  output logic [BW-1:0]                       bin
);

  import bsfl_pkg::*;

  localparam int LW = $clog2(MAX_BINS + 2);

  logic [LW-1:0] lo, lo_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] half, mid, mid_next, lo_c;
  logic          ge;
  logic          lt0;

  // ge: coordinate not below the edge on the read port
  assign ge = !(coord < rdata);

  always_comb begin
    half    = len >> 1;
    mid     = lo + half;
    lo_next = lo;
    len_next = len;
    if (cmd.init) begin
      lo_next  = '0;
      len_next = LW'(n) + LW'(1);
    end else if (cmd.step && (len != '0)) begin
      if (ge) begin
        lo_next  = mid + LW'(1);
        len_next = len - half - LW'(1);
      end else begin
        len_next = half;
      end
    end
    mid_next = lo_next + (len_next >> 1);
  end

  always_comb begin
    case (cmd.edge_sel)
      SEL_LAST: raddr = n;
      SEL_MID:  raddr = (len_next == '0) ? '0 : mid_next[AW-1:0];
      default:  raddr = '0;
    endcase
  end

  assign done = (len_next == '0);
  assign oor  = lt0 | ge;

  always_comb begin
    if (lo == '0) begin
      lo_c = LW'(1);
    end else if (lo > LW'(n)) begin
      lo_c = LW'(n);
    end else begin
      lo_c = lo;
    end
  end

  assign bin = BW'(lo_c - LW'(1));

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    len <= len_next;
    if (cmd.chk_lo) begin
      lt0 <= !ge;
    end
  end

endmodule

### src/bsfl_datapath.sv
module bsfl_datapath #(
  parameter int MAX_X_BINS = 32,
  parameter int MAX_Y_BINS = 32
) (
  input  logic                                 clk,
  input  bsfl_pkg::cmd_t                       cmd,
  output bsfl_pkg::status_t                    status,
  input  logic                                 accept,
  input  logic [bsfl_pkg::COUNT_W-1:0]         x_bin_count,
  input  logic [bsfl_pkg::COUNT_W-1:0]         y_bin_count,
  input  logic [bsfl_pkg::OP_W-1:0]            operation,
  input  logic [bsfl_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [bsfl_pkg::WORD_W-1:0]   load_word,
  input  logic signed [bsfl_pkg::WORD_W-1:0]   x_coord,
  input  logic signed [bsfl_pkg::WORD_W-1:0]   y_coord,
  input  logic signed [bsfl_pkg::SHIFT_W-1:0]  shift_sigma,
  output logic [bsfl_pkg::WORD_W-1:0]          scale_factor,
  output logic                                 in_range
);

  import bsfl_pkg::*;

  localparam int XAW    = $clog2(MAX_X_BINS + 1);
  localparam int YAW    = $clog2(MAX_Y_BINS + 1);
  localparam int XBW    = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
  localparam int YBW    = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
  localparam int CDEPTH = MAX_X_BINS * MAX_Y_BINS;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int IW     = ((CAW > INDEX_W) ? CAW : INDEX_W) + 1;
  localparam int XCW    = ((XAW > COUNT_W) ? XAW : COUNT_W);
  localparam int YCW    = ((YAW > COUNT_W) ? YAW : COUNT_W);

  op_t                       op;
  logic [IW-1:0]             idx_ext;
  logic                      we_x, we_y, we_val, we_err;

  logic [XCW-1:0]            cx;
  logic [YCW-1:0]            cy;
  logic [XAW-1:0]            nx;
  logic [YAW-1:0]            ny;

  logic signed [WORD_W-1:0]  x_q, y_q;
  logic signed [SHIFT_W-1:0] shift_q;

  logic [XAW-1:0]            x_raddr;
  logic [YAW-1:0]            y_raddr;
  logic [WORD_W-1:0]         x_rdata, y_rdata;
  logic                      oor_x, oor_y, done_x, done_y;
  logic [XBW-1:0]            col;
  logic [YBW-1:0]            row;
  logic                      oor_q;

  logic [CAW-1:0]            cell_addr;
  logic [WORD_W-1:0]         val_rdata, err_rdata;
  logic signed [WORD_W-1:0]  val_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SUM_W-1:0]   sum;
  logic [WORD_W-1:0]         sat;

  // load decode
  assign op      = op_t'(operation);
  assign idx_ext = IW'(entry_index);
  assign we_x    = accept && (op == OP_WR_X)   && (idx_ext <= IW'(MAX_X_BINS));
  assign we_y    = accept && (op == OP_WR_Y)   && (idx_ext <= IW'(MAX_Y_BINS));
  assign we_val  = accept && (op == OP_WR_VAL) && (idx_ext < IW'(CDEPTH));
  assign we_err  = accept && (op == OP_WR_ERR) && (idx_ext < IW'(CDEPTH));

  // bin counts: zero acts as one, large values as the maximum
  assign cx = XCW'(x_bin_count);
  assign cy = YCW'(y_bin_count);

  always_comb begin
    if (cx == '0) begin
      nx = XAW'(1);
    end else if (cx > XCW'(MAX_X_BINS)) begin
      nx = XAW'(MAX_X_BINS);
    end else begin
      nx = XAW'(cx);
    end
    if (cy == '0) begin
      ny = YAW'(1);
    end else if (cy > YCW'(MAX_Y_BINS)) begin
      ny = YAW'(MAX_Y_BINS);
    end else begin
      ny = YAW'(cy);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_q     <= x_coord;
      y_q     <= y_coord;
      shift_q <= shift_sigma;
    end
  end

  bsfl_ram #(.WIDTH(WORD_W), .DEPTH(MAX_X_BINS + 1)) u_x_edges (
    .clk   (clk),
    .we    (we_x),
    .waddr (idx_ext[XAW-1:0]),
    .wdata (load_word),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  bsfl_ram #(.WIDTH(WORD_W), .DEPTH(MAX_Y_BINS + 1)) u_y_edges (
    .clk   (clk),
    .we    (we_y),
    .waddr (idx_ext[YAW-1:0]),
    .wdata (load_word),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  bsfl_search #(.MAX_BINS(MAX_X_BINS)) u_x_search (
    .clk   (clk),
    .cmd   (cmd),
    .coord (x_q),
    .n     (nx),
    .rdata ($signed(x_rdata)),
    .raddr (x_raddr),
    .oor   (oor_x),
    .done  (done_x),
    .bin   (col)
  );

  bsfl_search #(.MAX_BINS(MAX_Y_BINS)) u_y_search (
    .clk   (clk),
    .cmd   (cmd),
    .coord (y_q),
    .n     (ny),
    .rdata ($signed(y_rdata)),
    .raddr (y_raddr),
    .oor   (oor_y),
    .done  (done_y),
    .bin   (row)
  );

  assign status.oor         = oor_x | oor_y;
  assign status.search_done = done_x & done_y;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      oor_q <= oor_x | oor_y;
    end
  end

  // row-major cell address, never beyond the table
  assign cell_addr = CAW'(CAW'(row) * CAW'(nx)) + CAW'(col);

  bsfl_ram #(.WIDTH(WORD_W), .DEPTH(CDEPTH)) u_cell_values (
    .clk   (clk),
    .we    (we_val),
    .waddr (idx_ext[CAW-1:0]),
    .wdata (load_word),
    .raddr (cell_addr),
    .rdata (val_rdata)
  );

  bsfl_ram #(.WIDTH(WORD_W), .DEPTH(CDEPTH)) u_cell_errors (
    .clk   (clk),
    .we    (we_err),
    .waddr (idx_ext[CAW-1:0]),
    .wdata (load_word),
    .raddr (cell_addr),
    .rdata (err_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= PROD_W'(shift_q * $signed(err_rdata));
      val_q  <= $signed(val_rdata);
    end
  end

  // value*256 + shift*error in Q24.24, then back to Q16.16
  assign sum = $signed({{(SUM_W - WORD_W - 8){val_q[WORD_W-1]}}, val_q, 8'b0})
             + $signed({prod_q[PROD_W-1], prod_q});

  always_comb begin
    if (sum[SUM_W-1] || (sum == '0)) begin
      sat = '0;
    end else if (|sum[SUM_W-2:WORD_W+8]) begin
      sat = '1;
    end else begin
      sat = sum[WORD_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      scale_factor <= oor_q ? ONE_Q16 : sat;
      in_range     <= !oor_q;
    end
  end

endmodule

### src/bsfl_ctrl.sv
`include "binned_2d_scale_factor_lookup_assert.svh"

module bsfl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsfl_pkg::OP_W-1:0]     operation,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bsfl_pkg::cmd_t                cmd,
  input  bsfl_pkg::status_t             status
);

  import bsfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_HI,
    S_CHECK,
    S_SEARCH,
    S_CELL,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (op_t'(operation) == OP_EVAL)) begin
          cmd.capture  = 1'b1;
          cmd.edge_sel = SEL_FIRST;
          state_next   = S_RD_HI;
        end
      end
      S_RD_HI: begin
        cmd.chk_lo   = 1'b1;
        cmd.edge_sel = SEL_LAST;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check    = 1'b1;
        cmd.init     = 1'b1;
        cmd.edge_sel = SEL_MID;
        state_next   = status.oor ? S_FINISH : S_SEARCH;
      end
      S_SEARCH: begin
        cmd.step     = 1'b1;
        cmd.edge_sel = SEL_MID;
        if (status.search_done) begin
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BSFL_ASSERT_NEXT(a_eval_busy, clk, rst, accept && (op_t'(operation) == OP_EVAL), !in_ready)
  `BSFL_ASSERT_NEXT(a_load_shows, clk, rst, cmd.load_out, out_valid)
  `BSFL_ASSERT_NOW(a_no_load_idle, clk, rst, in_ready, !cmd.load_out)
  `BSFL_ASSERT_NOW(a_rise_after_finish, clk, rst, $rose(out_valid), $past(state == S_FINISH))

endmodule

### src/binned_2d_scale_factor_lookup.sv
// Channel  Direction  Handshake             Payload
// config   in         APB psel/penable      paddr[2] selects x_bin_count / y_bin_count
// in       in         in_valid/in_ready     operation, entry_index, load_word,
//                                           x_coord, y_coord, shift_sigma
// out      out        out_valid/out_ready   scale_factor, in_range
//
// Load items (edge, value, error writes) are written on accept; in_ready stays high.
// An evaluate item runs a range check against the first and last edges, then the
// binary-search probes (both axes in parallel), then the cell read and multiply-add;
// a point outside skips from the range check to the output. in_ready stays low until
// the result is loaded. The edge memories give one probe per cycle.
// rst is synchronous: bin counts go to 1, controller idles, no item is held.
// The output register lets the next item in while a result waits on out_ready.
// Tables have no reset; read only entries that were written.
module binned_2d_scale_factor_lookup #(
  parameter int MAX_X_BINS = 32,
  parameter int MAX_Y_BINS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bsfl_pkg::PADDR_W-1:0]         paddr,
  input  logic [bsfl_pkg::PDATA_W-1:0]         pwdata,
  output logic [bsfl_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bsfl_pkg::OP_W-1:0]            operation,
  input  logic [bsfl_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [bsfl_pkg::WORD_W-1:0]   load_word,
  input  logic signed [bsfl_pkg::WORD_W-1:0]   x_coord,
  input  logic signed [bsfl_pkg::WORD_W-1:0]   y_coord,
  input  logic signed [bsfl_pkg::SHIFT_W-1:0]  shift_sigma,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bsfl_pkg::WORD_W-1:0]          scale_factor,
  output logic                                 in_range
);

  import bsfl_pkg::*;

  logic [COUNT_W-1:0] x_bin_count;
  logic [COUNT_W-1:0] y_bin_count;
  logic               cfg_wr;
  logic               reg_sel;
  cmd_t               cmd;
  status_t            status;

  // register file: word address, paddr[2] picks the register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_bin_count <= COUNT_W'(1);
      y_bin_count <= COUNT_W'(1);
    end else if (cfg_wr) begin
      if (reg_sel == REG_X_BINS) begin
        x_bin_count <= pwdata[COUNT_W-1:0];
      end else begin
        y_bin_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_Y_BINS) begin
      prdata = PDATA_W'(y_bin_count);
    end else begin
      prdata = PDATA_W'(x_bin_count);
    end
  end

  // sequencing: range check, search probes, cell read, multiply-add, deliver
  bsfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // tables, search units, multiply-add and output register
  bsfl_datapath #(
    .MAX_X_BINS (MAX_X_BINS),
    .MAX_Y_BINS (MAX_Y_BINS)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .accept       (in_valid && in_ready),
    .x_bin_count  (x_bin_count),
    .y_bin_count  (y_bin_count),
    .operation    (operation),
    .entry_index  (entry_index),
    .load_word    (load_word),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .shift_sigma  (shift_sigma),
    .scale_factor (scale_factor),
    .in_range     (in_range)
  );

endmodule
